[hdl/sstw_pkg.sv]
// ----------------------------------------------------------------------------
// Seven-segment text writer package
// Shared types, constants and a lookup function for the text writer blocks.
// ----------------------------------------------------------------------------
package sstw_pkg;

    // Number of logical digit positions on the panel.
    localparam int POSITIONS = 16;
    localparam int POS_W     = $clog2(POSITIONS + 1);
    localparam int COL_W     = 4;
    localparam int CHAR_W    = 8;
    localparam int PAT_W     = 7;
    localparam int SEG_W     = 8;
    localparam int START_W   = 4;
    localparam int DCOUNT_W  = 5;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Register reset value.
    localparam logic [DCOUNT_W-1:0] DIGIT_COUNT_RESET = DCOUNT_W'(POSITIONS);

    // Character codes with a special meaning.
    localparam logic [CHAR_W-1:0] CHAR_END   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;

    // Logical position to physical column map.
    localparam logic [COL_W-1:0] COLUMN_OF [16] = '{
        4'd4,  4'd5,  4'd6,  4'd7,  4'd0, 4'd1, 4'd2,  4'd3,
        4'd12, 4'd13, 4'd14, 4'd15, 4'd8, 4'd9, 4'd10, 4'd11
    };

    // What the front found a character to be.
    typedef enum logic [1:0] {
        KIND_END   = 2'd0,
        KIND_POINT = 2'd1,
        KIND_DRAW  = 2'd2
    } t_kind;

    // One classified item travelling from front to back.
    typedef struct packed {
        t_kind                kind;
        logic [PAT_W-1:0]     pattern;
        logic                 begin_string;
        logic [START_W-1:0]   start_position;
    } t_class_item;

    // One result item.
    typedef struct packed {
        logic                 write_valid;
        logic [COL_W-1:0]     column;
        logic [SEG_W-1:0]     segments;
        logic                 string_done;
        logic [DCOUNT_W-1:0]  digits_written;
        logic                 truncated;
    } t_result;

    // Segment pattern of a drawable character; unknown characters draw blank.
    function automatic logic [PAT_W-1:0] segment_pattern(input logic [CHAR_W-1:0] ch);
        logic [PAT_W-1:0] pat;
        unique case (ch)
            8'h30:   pat = 7'h3F;
            8'h31:   pat = 7'h06;
            8'h32:   pat = 7'h5B;
            8'h33:   pat = 7'h4F;
            8'h34:   pat = 7'h66;
            8'h35:   pat = 7'h6D;
            8'h36:   pat = 7'h7D;
            8'h37:   pat = 7'h07;
            8'h38:   pat = 7'h7F;
            8'h39:   pat = 7'h6F;
            8'h2D:   pat = 7'h40;
            8'h7E:   pat = 7'h63;
            8'h63:   pat = 7'h61;
            8'h66:   pat = 7'h71;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

endpackage

[hdl/sstw_front.sv]
// ----------------------------------------------------------------------------
// Text writer front end
// Accepts characters, classifies them and holds one classified item.
// ----------------------------------------------------------------------------
module sstw_front
    import sstw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CHAR_W-1:0]   i_character,
    input  logic                i_begin_string,
    input  logic [START_W-1:0]  i_start_position,
    output logic                o_item_valid,
    input  logic                i_item_ready,
    output t_class_item         o_item
);

    logic         r_valid;
    logic         n_valid;
    t_class_item  r_item;
    t_class_item  n_item;
    logic         accept;

    // The holding register frees up when the queue takes its item.
    assign o_in_ready = !r_valid || i_item_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Classify the incoming character.
    always_comb begin
        n_item.begin_string   = i_begin_string;
        n_item.start_position = i_start_position;
        n_item.pattern        = segment_pattern(i_character);
        if (i_character == CHAR_END) begin
            n_item.kind = KIND_END;
        end else if (i_character == CHAR_COLON || i_character == CHAR_DOT) begin
            n_item.kind = KIND_POINT;
        end else begin
            n_item.kind = KIND_DRAW;
        end
    end

    // Valid flag of the holding register.
    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_item_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

[hdl/sstw_queue.sv]
// ----------------------------------------------------------------------------
// Text writer queue
// Short first-in first-out buffer of classified items between front and back.
// ----------------------------------------------------------------------------
module sstw_queue
    import sstw_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_valid,
    output logic         o_push_ready,
    input  t_class_item  i_push_item,
    output logic         o_pop_valid,
    input  logic         i_pop_ready,
    output t_class_item  o_pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_class_item       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_W-1:0]  n_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_item   = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage for queued items.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

[hdl/sstw_back.sv]
// ----------------------------------------------------------------------------
// Text writer back end
// Keeps the string state, draws digits and registers each result item.
// ----------------------------------------------------------------------------
module sstw_back
    import sstw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [DCOUNT_W-1:0]  i_digit_count,
    input  logic                 i_item_valid,
    output logic                 o_item_ready,
    input  t_class_item          i_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_result              o_result
);

    logic [POS_W-1:0]    r_position;
    logic [START_W-1:0]  r_first;
    logic                r_point;
    logic                r_stopped;
    logic [POS_W-1:0]    n_position;
    logic [START_W-1:0]  n_first;
    logic                n_point;
    logic                n_stopped;
    logic                r_out_valid;
    logic                n_out_valid;
    t_result             r_result;
    t_result             n_result;
    logic                has_result;
    logic                fire;
    logic [POS_W-1:0]    active;
    logic [POS_W-1:0]    pos_eff;
    logic [START_W-1:0]  first_eff;
    logic                point_eff;
    logic                stopped_eff;

    // An item is carried out whenever the output register can take a result.
    assign o_item_ready = !r_out_valid || i_out_ready;
    assign fire         = i_item_valid && o_item_ready;

    // A digit count of zero or past the panel width means the whole panel.
    always_comb begin
        if (i_digit_count == '0 || i_digit_count > DCOUNT_W'(POSITIONS)) begin
            active = POS_W'(POSITIONS);
        end else begin
            active = POS_W'(i_digit_count);
        end
    end

    // A begin flag restarts the string before the character is handled.
    always_comb begin
        if (i_item.begin_string) begin
            pos_eff     = POS_W'(i_item.start_position);
            first_eff   = i_item.start_position;
            point_eff   = 1'b0;
            stopped_eff = 1'b0;
        end else begin
            pos_eff     = r_position;
            first_eff   = r_first;
            point_eff   = r_point;
            stopped_eff = r_stopped;
        end
    end

    // Carry out the classified character.
    always_comb begin
        n_position = pos_eff;
        n_first    = first_eff;
        n_point    = point_eff;
        n_stopped  = stopped_eff;
        has_result = 1'b0;
        n_result   = '0;
        unique case (i_item.kind)
            KIND_END: begin
                has_result              = 1'b1;
                n_result.string_done    = 1'b1;
                n_result.digits_written = DCOUNT_W'(pos_eff - POS_W'(first_eff));
                n_result.truncated      = stopped_eff;
            end
            KIND_POINT: begin
                if (!stopped_eff) begin
                    n_point = 1'b1;
                end
            end
            KIND_DRAW: begin
                if (!stopped_eff) begin
                    if (pos_eff >= active) begin
                        n_stopped = 1'b1;
                    end else begin
                        has_result           = 1'b1;
                        n_result.write_valid = 1'b1;
                        n_result.column      = COLUMN_OF[pos_eff[COL_W-1:0]];
                        n_result.segments    = {point_eff, i_item.pattern};
                        n_point              = 1'b0;
                        n_position           = pos_eff + 1'b1;
                    end
                end
            end
            default: begin
                has_result = 1'b0;
            end
        endcase
    end

    // Output register valid flag.
    always_comb begin
        if (fire) begin
            n_out_valid = has_result;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= '0;
            r_first     <= '0;
            r_point     <= 1'b0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (fire) begin
                r_position <= n_position;
                r_first    <= n_first;
                r_point    <= n_point;
                r_stopped  <= n_stopped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && has_result) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    // A result is either a digit write or a string end, never both.
    a_write_or_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.write_valid != r_result.string_done))
        else $error("result is neither a single write nor a single end");

    // The running position never passes the panel width.
    a_position_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position <= POS_W'(POSITIONS))
        else $error("running position past the panel width");

    // The running position never falls behind the string start.
    a_position_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position >= POS_W'(r_first))
        else $error("running position behind the string start");

    // An end result never reports more digits than the panel holds.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.string_done) |->
            (r_result.digits_written <= DCOUNT_W'(POSITIONS)))
        else $error("digit count past the panel width");

endmodule

[hdl/seven_segment_text_writer.sv]
// ----------------------------------------------------------------------------
// Seven-segment text writer
// Turns a character string into column and segment writes for a 16-column
// seven-segment panel.
// ----------------------------------------------------------------------------
// The block takes one character item per clock cycle unless back-pressure
// stalls it, and gives at most one result per item. An item passes a
// classifying register in the front, a two-entry queue and the state and
// output register in the back; with the output side always ready, throughput
// is one item every cycle. The queue decouples the two sides: the front takes
// new items while a finished result waits, until the queue fills. Colons,
// dots and characters ignored after truncation give no result. The digit
// count register may only be written while no item is in flight.
module seven_segment_text_writer
    import sstw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [DCOUNT_W-1:0]  i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CHAR_W-1:0]    i_character,
    input  logic                 i_begin_string,
    input  logic [START_W-1:0]   i_start_position,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_write_valid,
    output logic [COL_W-1:0]     o_column,
    output logic [SEG_W-1:0]     o_segments,
    output logic                 o_string_done,
    output logic [DCOUNT_W-1:0]  o_digits_written,
    output logic                 o_truncated
);

    logic [DCOUNT_W-1:0]  r_digit_count;
    logic                 front_valid;
    logic                 front_ready;
    t_class_item          front_item;
    logic                 queue_valid;
    logic                 queue_ready;
    t_class_item          queue_item;
    t_result              result;

    // Digit count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= DIGIT_COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_digit_count <= i_cfg_wr_data;
        end
    end

    sstw_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_character      (i_character),
        .i_begin_string   (i_begin_string),
        .i_start_position (i_start_position),
        .o_item_valid     (front_valid),
        .i_item_ready     (front_ready),
        .o_item           (front_item)
    );

    sstw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_item   (queue_item)
    );

    sstw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_digit_count (r_digit_count),
        .i_item_valid  (queue_valid),
        .o_item_ready  (queue_ready),
        .i_item        (queue_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result      (result)
    );

    assign o_write_valid    = result.write_valid;
    assign o_column         = result.column;
    assign o_segments       = result.segments;
    assign o_string_done    = result.string_done;
    assign o_digits_written = result.digits_written;
    assign o_truncated      = result.truncated;

endmodule

[tb/sv/seven_segment_text_writer_tb.sv]
// ----------------------------------------------------------------------------
// Seven-segment text writer testbench
// Sends directed and random character strings through the text writer,
// predicts every column write and end-of-string report in a scoreboard, and
// compares each result field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module seven_segment_text_writer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sstw_pkg::*;

    // Cycles to let the pipeline empty out; items without a result leave nothing
    // to wait on.
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 215;

    // Predicts the writes and end reports from the characters accepted so far.
    class segment_scoreboard;
        logic [DCOUNT_W-1:0] digit_count;
        logic [4:0]          cur_pos;
        logic [3:0]          first_pos;
        logic                point_armed;
        logic                halted;
        t_result             awaited[$];
        int                  errors;

        function new();
            digit_count = DIGIT_COUNT_RESET;
            cur_pos     = '0;
            first_pos   = '0;
            point_armed = 1'b0;
            halted      = 1'b0;
            errors      = 0;
        endfunction

        // A digit count of zero or above the panel size means the whole panel.
        function int active_digits();
            if (digit_count == 0 || digit_count > POSITIONS) begin
                return POSITIONS;
            end
            return digit_count;
        endfunction

        function logic [PAT_W-1:0] glyph_of(logic [CHAR_W-1:0] ch);
            case (ch)
                "0":     return 7'h3F;
                "1":     return 7'h06;
                "2":     return 7'h5B;
                "3":     return 7'h4F;
                "4":     return 7'h66;
                "5":     return 7'h6D;
                "6":     return 7'h7D;
                "7":     return 7'h07;
                "8":     return 7'h7F;
                "9":     return 7'h6F;
                "-":     return 7'h40;
                "~":     return 7'h63;
                "c":     return 7'h61;
                "f":     return 7'h71;
                default: return 7'h00;
            endcase
        endfunction

        // Advance the predicted state by one accepted item.
        function void note_item(logic [CHAR_W-1:0] ch, logic first, logic [START_W-1:0] sp);
            t_result r;
            r = '0;
            if (first) begin
                cur_pos     = {1'b0, sp};
                first_pos   = sp;
                point_armed = 1'b0;
                halted      = 1'b0;
            end
            if (ch == CHAR_END) begin
                r.string_done    = 1'b1;
                r.digits_written = cur_pos - {1'b0, first_pos};
                r.truncated      = halted;
                awaited.push_back(r);
            end else if (!halted) begin
                if (ch == CHAR_COLON || ch == CHAR_DOT) begin
                    point_armed = 1'b1;
                end else if (cur_pos >= active_digits()) begin
                    halted = 1'b1;
                end else begin
                    // Logical to physical column: halves of each group of eight swap.
                    r.write_valid = 1'b1;
                    r.column      = {cur_pos[3], ~cur_pos[2], cur_pos[1:0]};
                    r.segments    = {point_armed, glyph_of(ch)};
                    point_armed   = 1'b0;
                    cur_pos       = cur_pos + 5'd1;
                    awaited.push_back(r);
                end
            end
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
            errors++;
        endtask

        task compare_field(string what, int got, int want);
            if (got != want) begin
                report_mismatch(what, got, want);
            end
        endtask

        // Compare one accepted result with the oldest prediction.
        task check_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                report_mismatch("unexpected result", got, 0);
            end else begin
                want = awaited.pop_front();
                compare_field("write_valid", got.write_valid, want.write_valid);
                compare_field("column", got.column, want.column);
                compare_field("segments", got.segments, want.segments);
                compare_field("string_done", got.string_done, want.string_done);
                compare_field("digits_written", got.digits_written, want.digits_written);
                compare_field("truncated", got.truncated, want.truncated);
            end
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [DCOUNT_W-1:0]  i_cfg_wr_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [CHAR_W-1:0]    i_character;
    logic                 i_begin_string;
    logic [START_W-1:0]   i_start_position;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_write_valid;
    logic [COL_W-1:0]     o_column;
    logic [SEG_W-1:0]     o_segments;
    logic                 o_string_done;
    logic [DCOUNT_W-1:0]  o_digits_written;
    logic                 o_truncated;

    segment_scoreboard sb = new();

    bit no_gaps;
    bit hold_req;
    int items_sent;
    int cycle_count;

    seven_segment_text_writer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_character      (i_character),
        .i_begin_string   (i_begin_string),
        .i_start_position (i_start_position),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_write_valid    (o_write_valid),
        .o_column         (o_column),
        .o_segments       (o_segments),
        .o_string_done    (o_string_done),
        .o_digits_written (o_digits_written),
        .o_truncated      (o_truncated)
    );

    // Free-running clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** seven_segment_text_writer: FAILED **");
            $finish;
        end
    end

    // Result side: check at the rising edge, choose ready at the falling edge.
    initial begin
        int  hold_left;
        bit  hold_taken;
        hold_left   = 0;
        hold_taken  = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                sb.check_result({o_write_valid, o_column, o_segments, o_string_done,
                                 o_digits_written, o_truncated});
            end
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!no_gaps && $urandom_range(0, 99) < 25) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offer one item, starting and ending at a falling edge.
    task automatic send_item(logic [CHAR_W-1:0] ch, logic first, logic [START_W-1:0] sp);
        int gap;
        if (!no_gaps && $urandom_range(0, 99) < 22) begin
            gap = $urandom_range(1, 2);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_character      <= ch;
        i_begin_string   <= first;
        i_start_position <= sp;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sb.note_item(ch, first, sp);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Mostly drawable characters, some points, stray ends and arbitrary codes.
    function automatic logic [CHAR_W-1:0] pick_char();
        string glyphs;
        int    r;
        glyphs = "0123456789-~cf";
        r      = $urandom_range(0, 99);
        if (r < 55) begin
            return glyphs[$urandom_range(0, 13)];
        end else if (r < 70) begin
            return $urandom_range(0, 1) ? CHAR_DOT : CHAR_COLON;
        end else if (r < 72) begin
            return CHAR_END;
        end
        return CHAR_W'($urandom_range(1, 255));
    endfunction

    // One string; a few lack the begin flag or the terminating zero.
    task automatic send_random_string();
        int               len;
        int               lim;
        bit               with_begin;
        bit               with_end;
        logic [START_W-1:0] start;
        lim        = sb.active_digits();
        with_begin = ($urandom_range(0, 99) < 90);
        with_end   = ($urandom_range(0, 99) < 92);
        start      = $urandom_range(0, 2) == 0 ? START_W'($urandom_range(0, 15))
                                               : START_W'($urandom_range(0, lim - 1));
        len        = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24)
                                                 : $urandom_range(0, lim + 3);
        for (int k = 0; k < len; k++) begin
            send_item(pick_char(), with_begin && k == 0,
                      k == 0 ? start : START_W'($urandom));
        end
        if (with_end) begin
            send_item(CHAR_END, with_begin && len == 0, len == 0 ? start : START_W'($urandom));
        end
    endtask

    // Stop offering and wait until every item has left the block.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Register write while idle; the predictor follows at the same point.
    task automatic write_digit_count(logic [DCOUNT_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.digit_count = value;
    endtask

    // Main sequence: reset, directed strings, then random phases per setting.
    initial begin
        string                text;
        logic [DCOUNT_W-1:0]  plan[9];
        int                   phase_end;
        i_rst_n          <= 1'b0;
        i_cfg_wr_en      <= 1'b0;
        i_cfg_wr_data    <= '0;
        i_in_valid       <= 1'b0;
        i_character      <= '0;
        i_begin_string   <= 1'b0;
        i_start_position <= '0;
        no_gaps          = 1'b0;
        hold_req         = 1'b0;
        items_sent       = 0;
        cycle_count      = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Every glyph, merged points and a full panel, then running off the end.
        text = "0123456789-.~::cf";
        for (int i = 0; i < text.len(); i++) begin
            send_item(text[i], i == 0, 4'd0);
        end
        send_item(8'hFF, 1'b0, 4'hF);
        send_item("A", 1'b0, 4'h0);
        send_item("5", 1'b0, 4'h0);
        send_item(CHAR_DOT, 1'b0, 4'h0);
        send_item(CHAR_END, 1'b0, 4'h0);
        send_item(CHAR_END, 1'b0, 4'h0);
        // Empty string, then a point left over at the end of a string.
        send_item(CHAR_END, 1'b1, 4'd15);
        send_item("7", 1'b1, 4'd15);
        send_item(CHAR_DOT, 1'b0, 4'h0);
        send_item(CHAR_END, 1'b0, 4'h0);
        // Continue the old string without a begin flag.
        send_item("8", 1'b0, 4'h0);
        send_item(CHAR_END, 1'b0, 4'h0);
        drain();

        // A start beyond a one-digit panel draws nothing.
        write_digit_count(5'd1);
        send_item("3", 1'b1, 4'd4);
        send_item(CHAR_COLON, 1'b0, 4'd0);
        send_item(CHAR_END, 1'b0, 4'd0);
        drain();

        // Random phases, one register setting each; reset value first.
        plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd16,
                 DCOUNT_W'($urandom_range(2, 15)), DCOUNT_W'($urandom_range(2, 15)), 5'd2};
        for (int p = 0; p < 9; p++) begin
            write_digit_count(plan[p]);
            no_gaps  = (p == 3);
            hold_req = hold_req || (p == 1);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) send_random_string();
            drain();
        end
        no_gaps = 1'b0;

        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("** seven_segment_text_writer: PASSED **");
        end else begin
            $display("** seven_segment_text_writer: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/sstw_pkg.sv
hdl/sstw_front.sv
hdl/sstw_queue.sv
hdl/sstw_back.sv
hdl/seven_segment_text_writer.sv
tb/sv/seven_segment_text_writer_tb.sv
